// ----- design/tcpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcpc_pkg: shared types and constants of the color palette collector
// Pixel, result and outcome types, register indexes and the color compare.
// ----------------------------------------------------------------------------
package tcpc_pkg;

   localparam int TCPC_MAX_COLORS = 16;

   localparam logic [7:0] TOLERANCE_RESET = 8'd40;
   localparam logic [7:0] REFERENCE_RESET = 8'd255;

   // register indexes on the csr channel
   localparam logic [7:0] CSR_MATCH_TOLERANCE = 8'd0;
   localparam logic [7:0] CSR_REFERENCE_BLUE  = 8'd1;
   localparam logic [7:0] CSR_REFERENCE_GREEN = 8'd2;
   localparam logic [7:0] CSR_REFERENCE_RED   = 8'd3;

   typedef enum logic [1:0] {
      OUT_SKIPPED  = 2'd0,
      OUT_MATCHED  = 2'd1,
      OUT_APPENDED = 2'd2,
      OUT_DROPPED  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      outcome_type outcome;
      logic [3:0]  entry_index;
      logic [4:0]  stored_count;
   } result_type;

   function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // every channel within tolerance
   function automatic logic color_near(pixel_type a, pixel_type b, logic [7:0] tol);
      return (abs_diff(a.blue, b.blue) <= tol) &&
             (abs_diff(a.green, b.green) <= tol) &&
             (abs_diff(a.red, b.red) <= tol);
   endfunction

endpackage
`default_nettype wire

// ----- design/tcpc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcpc_if: channel interfaces of the color palette collector
// Pixel request, result response and register write channels.
// ----------------------------------------------------------------------------
interface tcpc_req_if;
   logic       valid;
   logic       ready;
   logic       start_image;
   logic [7:0] pixel_blue;
   logic [7:0] pixel_green;
   logic [7:0] pixel_red;

   modport source (output valid, start_image, pixel_blue, pixel_green, pixel_red,
                   input ready);
   modport sink (input valid, start_image, pixel_blue, pixel_green, pixel_red,
                 output ready);
endinterface

interface tcpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   logic [3:0] entry_index;
   logic [4:0] stored_count;

   modport source (output valid, outcome, entry_index, stored_count, input ready);
   modport sink (input valid, outcome, entry_index, stored_count, output ready);
endinterface

interface tcpc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/tcpc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcpc_cell: one palette entry of the compare chain
// Holds one stored color, compares the passing pixel against it and hands
// the pixel with its match flag and index on to the next cell.
// ----------------------------------------------------------------------------
module tcpc_cell
   import tcpc_pkg::*;
#(
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5,
   parameter int CELL_INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       tolerance,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire pixel_type        wr_pix,
   input  wire logic             in_vld,
   input  wire pixel_type        in_pix,
   input  wire logic             in_found,
   input  wire logic [IDX_W-1:0] in_idx,
   output      logic             out_vld,
   output      pixel_type        out_pix,
   output      logic             out_found,
   output      logic [IDX_W-1:0] out_idx
);

   pixel_type        entry_ff;
   logic             vld_ff;
   pixel_type        pix_ff;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit;

   // only entries below the fill count hold a color
   assign hit = (count > CNT_W'(CELL_INDEX)) && color_near(in_pix, entry_ff, tolerance);

   always_comb begin
      found_in = in_found;
      idx_in   = in_idx;
      if (!in_found && hit) begin
         found_in = 1'b1;
         idx_in   = IDX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == IDX_W'(CELL_INDEX))) begin
         entry_ff <= wr_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= in_pix;
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   assign out_vld   = vld_ff;
   assign out_pix   = pix_ff;
   assign out_found = found_ff;
   assign out_idx   = idx_ff;

endmodule
`default_nettype wire

// ----- design/tolerance_color_palette_collector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tolerance_color_palette_collector: palette builder with color tolerance
// Skips pixels near the reference color, reports the lowest stored entry a
// pixel matches, appends unmatched pixels and flags drops on a full palette.
// ----------------------------------------------------------------------------
// A pixel walks down a row of MAX_COLORS cells, one cell per clock, each cell
// holding one palette entry; one pixel is in the row at a time. An accepted
// pixel passes through every cell to the tail, where the outcome is decided
// and an append is written; no new pixel is taken before then. The result
// sits in an output register with one skid slot behind it, so a stalled
// response does not block the row; the next pixel waits until its
// predecessor's result has reached the output register.
// Register writes are taken at any time and must only occur while idle.
// ----------------------------------------------------------------------------
module tolerance_color_palette_collector
   import tcpc_pkg::*;
#(
   parameter int MAX_COLORS = TCPC_MAX_COLORS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tcpc_req_if.sink    req_chan,
   tcpc_rsp_if.source  rsp_chan,
   tcpc_csr_if.sink    csr_chan
);

   localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int CNT_W = $clog2(MAX_COLORS + 1);

   // configuration
   logic [7:0] tol_ff;
   pixel_type  ref_ff;

   // control
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_eff;
   logic             ref_hit_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   result_type       rsp_ff, rsp_in;
   logic             pend_vld_ff, pend_vld_in;
   result_type       pend_ff, pend_in;

   logic             req_fire;
   logic             rsp_free;
   pixel_type        req_pix;
   logic             wr_en;
   result_type       res;

   // compare chain taps
   logic             vld_chain   [0:MAX_COLORS];
   pixel_type        pix_chain   [0:MAX_COLORS];
   logic             found_chain [0:MAX_COLORS];
   logic [IDX_W-1:0] idx_chain   [0:MAX_COLORS];

   assign req_pix  = '{blue: req_chan.pixel_blue, green: req_chan.pixel_green,
                       red: req_chan.pixel_red};
   assign req_chan.ready = !busy_ff;
   assign req_fire = req_chan.valid && !busy_ff;
   assign csr_chan.ready = 1'b1;

   // a start pixel sees an empty palette from the first cell on
   assign count_eff = (req_fire && req_chan.start_image) ? '0 : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOLERANCE_RESET;
         ref_ff <= '{blue: REFERENCE_RESET, green: REFERENCE_RESET,
                     red: REFERENCE_RESET};
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MATCH_TOLERANCE: tol_ff <= csr_chan.data;
            CSR_REFERENCE_BLUE:  ref_ff.blue <= csr_chan.data;
            CSR_REFERENCE_GREEN: ref_ff.green <= csr_chan.data;
            CSR_REFERENCE_RED:   ref_ff.red <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // inject the pixel at the head of the row
   assign vld_chain[0]   = req_fire;
   assign pix_chain[0]   = req_pix;
   assign found_chain[0] = 1'b0;
   assign idx_chain[0]   = '0;

   generate
      for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
         tcpc_cell #(
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (i)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .tolerance (tol_ff),
            .count     (count_eff),
            .wr_en     (wr_en),
            .wr_idx    (count_ff[IDX_W-1:0]),
            .wr_pix    (pix_chain[MAX_COLORS]),
            .in_vld    (vld_chain[i]),
            .in_pix    (pix_chain[i]),
            .in_found  (found_chain[i]),
            .in_idx    (idx_chain[i]),
            .out_vld   (vld_chain[i+1]),
            .out_pix   (pix_chain[i+1]),
            .out_found (found_chain[i+1]),
            .out_idx   (idx_chain[i+1])
         );
      end
   endgenerate

   // decide at the tail of the row
   always_comb begin
      wr_en    = 1'b0;
      count_in = count_ff;
      res      = '{outcome: OUT_SKIPPED, entry_index: 4'd0, stored_count: 5'd0};
      if (req_fire && req_chan.start_image) begin
         count_in = '0;
      end
      if (vld_chain[MAX_COLORS]) begin
         if (ref_hit_ff) begin
            res.outcome = OUT_SKIPPED;
         end else if (found_chain[MAX_COLORS]) begin
            res.outcome     = OUT_MATCHED;
            res.entry_index = 4'(idx_chain[MAX_COLORS]);
         end else if (count_ff < CNT_W'(MAX_COLORS)) begin
            res.outcome     = OUT_APPENDED;
            res.entry_index = 4'(count_ff[IDX_W-1:0]);
            wr_en           = 1'b1;
            count_in        = count_ff + CNT_W'(1);
         end else begin
            res.outcome = OUT_DROPPED;
         end
      end
      res.stored_count = 5'(count_in);
   end

   assign rsp_free = !rsp_vld_ff || rsp_chan.ready;

   always_comb begin
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      busy_in     = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (rsp_free) begin
         if (pend_vld_ff) begin
            rsp_in      = pend_ff;
            rsp_vld_in  = 1'b1;
            pend_vld_in = 1'b0;
            busy_in     = 1'b0;
         end else if (vld_chain[MAX_COLORS]) begin
            rsp_in     = res;
            rsp_vld_in = 1'b1;
            busy_in    = 1'b0;
         end else begin
            rsp_vld_in = 1'b0;
         end
      end else if (vld_chain[MAX_COLORS]) begin
         // hold the result behind the stalled output
         pend_in     = res;
         pend_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         count_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         count_ff    <= count_in;
         rsp_vld_ff  <= rsp_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (req_fire) begin
         ref_hit_ff <= color_near(req_pix, ref_ff, tol_ff);
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.outcome      = rsp_ff.outcome;
   assign rsp_chan.entry_index  = rsp_ff.entry_index;
   assign rsp_chan.stored_count = rsp_ff.stored_count;

   logic [MAX_COLORS-1:0] chain_vld_vec;
   always_comb begin
      for (int k = 0; k < MAX_COLORS; k++) begin
         chain_vld_vec[k] = vld_chain[k+1];
      end
   end

   a_one_pixel_in_row: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld_vec))
      else $error("more than one pixel in the compare row");

   a_tail_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      vld_chain[MAX_COLORS] |-> busy_ff)
      else $error("pixel left the row while not busy");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COLORS))
      else $error("palette count beyond capacity");

   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (rsp_vld_ff && busy_ff))
      else $error("skid slot holds a result without a stalled output");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (busy_ff && !req_chan.ready))
      else $error("accepted pixel did not block the request channel");

endmodule
`default_nettype wire
